// ===== src/gsfc_pkg.sv =====
package gsfc_pkg;

	localparam int FRAME_DEPTH = 64;
	localparam int CNT_W       = 7;
	localparam int IDX_W       = 6;
	localparam int SAMPLE_W    = 16;
	localparam int TIME_W      = 32;
	localparam int CRC_W       = 16;
	localparam int HDR_BYTES   = 14;
	localparam int HDR_W       = HDR_BYTES * 8;
	localparam int BYTE_IDX_W  = $clog2(HDR_BYTES);

	localparam logic [CRC_W-1:0]    CRC_INIT      = 16'hFFFF;
	localparam logic [CRC_W-1:0]    CRC_POLY      = 16'hA001;
	localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET = 16'h8000;

	typedef enum logic [2:0] {
		ST_WAIT_RISE,
		ST_WAIT_FALL,
		ST_CAPTURE,
		ST_CRC,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic             done;
		logic [CRC_W-1:0] crc;
	} crc_stat_t;

	// Reflected CRC-16 update over one byte, one bit per step.
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
			input logic [7:0] data);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {8'h00, data};
		for (int j = 0; j < 8; j++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== src/gated_sample_frame_capture.sv =====
// Channel   Dir  Beat contents
// s_axis    in   tdata: raw_value, now_ms; tuser: tick, rise, fall, level, conversion_ok
// m_axis    out  tdata: frame header, CRC, sample index and value; tlast: final sample
//
// An input beat is accepted whenever valid while capturing or waiting for select edges.
// A beat that closes a frame starts a CRC pass over the header, one header byte per cycle,
// then the frame drains from the sample memory at one beat per cycle while the output is
// ready, set by its single read port with registered read data; input stalls meanwhile.
// Output back-pressure holds the read data register and stops further reads.
// Reset is asynchronous; the sample memory is not cleared and needs no clearing pass.
module gated_sample_frame_capture import gsfc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,  // raw_value[15:0], now_ms[47:16]
	input  logic [4:0]   s_tuser,  // sample_tick, select_rise, select_fall, select_level,
	                               // conversion_ok
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,  // frame_number, start_time, duration, sample_count,
	                               // header_crc, sample_index, sample_value, zero fill
	output logic         m_tlast
);

	state_t state_q, state_d;

	logic                in_fire, out_fire;
	logic                tick, rise, fall, level, conv_ok;
	logic [SAMPLE_W-1:0] raw_value;
	logic [TIME_W-1:0]   now_ms;

	logic [CNT_W-1:0]    fill_q;
	logic [TIME_W-1:0]   cap_start_q;
	logic [TIME_W-1:0]   hdr_number_q;
	logic [TIME_W-1:0]   hdr_start_q;
	logic [TIME_W-1:0]   hdr_dur_q;
	logic [CNT_W-1:0]    hdr_count_q;
	logic [CNT_W-1:0]    rd_cnt_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic                out_valid_q;

	logic                store;
	logic [CNT_W-1:0]    new_fill;
	logic                emit;
	logic                ram_wr_en;
	logic                ram_rd_en;
	logic [SAMPLE_W-1:0] ram_rd_data;
	logic                crc_start;
	logic [HDR_W-1:0]    hdr;
	crc_stat_t           crc_stat;

	assign tick      = s_tuser[0];
	assign rise      = s_tuser[1];
	assign fall      = s_tuser[2];
	assign level     = s_tuser[3];
	assign conv_ok   = s_tuser[4];
	assign raw_value = s_tdata[15:0];
	assign now_ms    = s_tdata[47:16];

	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	assign store    = tick && !level && conv_ok && (fill_q < CNT_W'(FRAME_DEPTH));
	assign new_fill = fill_q + {{(CNT_W-1){1'b0}}, store};
	assign emit     = rise && (new_fill != '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_WAIT_RISE: begin
				if (in_fire && rise) begin
					state_d = ST_WAIT_FALL;
				end
			end
			ST_WAIT_FALL: begin
				if (in_fire && fall) begin
					state_d = ST_CAPTURE;
				end
			end
			ST_CAPTURE: begin
				if (in_fire && emit) begin
					state_d = ST_CRC;
				end
			end
			ST_CRC: begin
				if (crc_stat.done) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_fire && m_tlast) begin
					state_d = ST_CAPTURE;
				end
			end
			default: state_d = ST_WAIT_RISE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		ram_wr_en = 1'b0;
		ram_rd_en = 1'b0;
		crc_start = 1'b0;
		unique case (state_q)
			ST_WAIT_RISE, ST_WAIT_FALL: begin
				s_tready = 1'b1;
			end
			ST_CAPTURE: begin
				s_tready  = 1'b1;
				ram_wr_en = s_tvalid && store;
				crc_start = s_tvalid && emit;
			end
			ST_CRC: begin
			end
			ST_DRAIN: begin
				ram_rd_en = (rd_cnt_q != hdr_count_q) && (!out_valid_q || m_tready);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_WAIT_RISE;
			fill_q       <= '0;
			cap_start_q  <= '0;
			hdr_number_q <= '0;
			rd_cnt_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_WAIT_FALL && in_fire && fall) begin
				fill_q      <= '0;
				cap_start_q <= now_ms;
			end
			if (state_q == ST_CAPTURE && in_fire) begin
				fill_q <= emit ? '0 : new_fill;
				if (emit || (fall && new_fill == '0)) begin
					cap_start_q <= now_ms;
				end
				if (emit) begin
					hdr_number_q <= hdr_number_q + 1'b1;
					rd_cnt_q     <= '0;
				end
			end
			if (ram_rd_en) begin
				rd_cnt_q    <= rd_cnt_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CAPTURE && in_fire && emit) begin
			hdr_start_q <= cap_start_q;
			hdr_dur_q   <= now_ms - cap_start_q;
			hdr_count_q <= new_fill;
		end
		if (ram_rd_en) begin
			out_idx_q <= rd_cnt_q[IDX_W-1:0];
		end
	end

	assign hdr = {{(16-CNT_W){1'b0}}, hdr_count_q, hdr_dur_q, hdr_start_q, hdr_number_q};

	gsfc_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (crc_start),
		.hdr    (hdr),
		.stat   (crc_stat)
	);

	gsfc_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (FRAME_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (fill_q[IDX_W-1:0]),
		.wr_data (raw_value ^ SAMPLE_OFFSET),
		.rd_en   (ram_rd_en),
		.rd_addr (rd_cnt_q[IDX_W-1:0]),
		.rd_data (ram_rd_data)
	);

	assign m_tvalid = out_valid_q;
	assign m_tlast  = ({1'b0, out_idx_q} + 1'b1) == hdr_count_q;
	assign m_tdata  = {3'b000, ram_rd_data, out_idx_q, crc_stat.crc, hdr_count_q,
		hdr_dur_q, hdr_start_q, hdr_number_q};

	a_out_only_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> state_q == ST_DRAIN)
		else $error("Output beat outside of the drain state.");

	a_write_only_capture: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en |-> state_q == ST_CAPTURE)
		else $error("Sample memory written outside of capture.");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(FRAME_DEPTH))
		else $error("Fill count exceeds the frame depth.");

	a_last_returns: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && m_tlast |=> state_q == ST_CAPTURE)
		else $error("Drain did not end on the last beat.");

	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> rd_cnt_q <= hdr_count_q)
		else $error("More reads issued than samples in the frame.");

endmodule

// ===== src/gsfc_ram.sv =====
module gsfc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/gsfc_crc.sv =====
module gsfc_crc import gsfc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [HDR_W-1:0] hdr,
	output crc_stat_t        stat
);

	logic                  busy_q;
	logic                  done_q;
	logic [BYTE_IDX_W-1:0] idx_q;
	logic [CRC_W-1:0]      crc_q;
	logic [7:0]            cur_byte;

	assign cur_byte = hdr[{idx_q, 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (idx_q == BYTE_IDX_W'(HDR_BYTES - 1));
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == BYTE_IDX_W'(HDR_BYTES - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			crc_q <= CRC_INIT;
		end else if (busy_q) begin
			crc_q <= crc_byte(crc_q, cur_byte);
		end
	end

	assign stat.done = done_q;
	assign stat.crc  = crc_q;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import gsfc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int RANDOM_ITEMS   = 45;
	localparam logic [7:0] NO_CHECK = 8'hFF;

	typedef struct packed {
		logic        tick;
		logic        rise;
		logic        fall;
		logic        level;
		logic        ok;
		logic [15:0] raw;
		logic [31:0] now;
	} cap_item_t;

	localparam int ITEM_W = $bits(cap_item_t);

	typedef struct packed {
		logic [31:0]         number;
		logic [31:0]         start;
		logic [31:0]         dur;
		logic [CNT_W-1:0]    count;
		logic [CRC_W-1:0]    crc;
		logic [IDX_W-1:0]    index;
		logic [SAMPLE_W-1:0] value;
		logic                last;
	} sample_beat_t;

	// One directed row; reps > 1 repeats the row with random raw values and a rising time.
	// want is the total number of output beats the row must cause.
	typedef struct packed {
		logic        tick;
		logic        rise;
		logic        fall;
		logic        level;
		logic        ok;
		logic [15:0] raw;
		logic [31:0] now;
		logic [7:0]  reps;
		logic [7:0]  want;
	} plan_row_t;

	localparam int PLAN_LEN = 20;
	plan_row_t plan [PLAN_LEN] = '{
		//  tick rise fall lvl ok  raw        now           reps want
		'{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 16'h1234, 32'd10,       8'd1, 8'd0},
		'{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 32'd20,       8'd1, 8'd0},
		'{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 32'd30,       8'd1, 8'd0},
		'{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 16'h5555, 32'd40,       8'd1, 8'd0},
		'{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 32'd100,      8'd1, 8'd0},
		'{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 16'h0000, 32'd110,      8'd1, 8'd0},
		'{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 16'hFFFF, 32'd120,      8'd1, 8'd0},
		'{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 16'h8000, 32'd130,      8'd1, 8'd0},
		'{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 16'hAAAA, 32'd140,      8'd1, 8'd0},
		'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'h5555, 32'd150,      8'd1, 8'd0},
		'{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 32'd50,       8'd1, 8'd3},
		'{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 32'd60,       8'd1, 8'd0},
		'{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 32'hFFFFFFFF, 8'd1, 8'd0},
		'{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 16'h1234, 32'd5,        8'd1, 8'd1},
		'{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 16'h7FFF, 32'd9,        8'd1, 8'd0},
		'{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 16'h0000, 32'd1000,     8'd66, 8'd0},
		'{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 32'hFFFFFFF0, 8'd1, 8'd64},
		'{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'h0001, 32'hFFFFFFFF, 8'd1, 8'd0},
		'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h00000000, 8'd1, 8'd0},
		'{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 16'hFEDC, 32'h80000000, 8'd1, 8'd1}
	};

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [47:0]  s_tdata;
	logic [4:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;
	logic         m_tlast;

	gated_sample_frame_capture u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Capture predictor state.
	state_t              cap_phase;
	logic [SAMPLE_W-1:0] cap_store [FRAME_DEPTH];
	int                  cap_fill;
	logic [31:0]         cap_start;
	logic [31:0]         cap_frames;

	sample_beat_t expected_beats [$];
	int           errors;
	int           idle_cycles;
	int           in_left, out_left;
	bit           in_calm, out_calm;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		if (errors <= 40) begin
			$display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
		end
	endtask

	function automatic logic [CRC_W-1:0] header_crc(input logic [HDR_W-1:0] hdr);
		logic [CRC_W-1:0] c;
		logic             fb;
		c = CRC_INIT;
		for (int i = 0; i < HDR_W; i++) begin
			fb = c[0] ^ hdr[i];
			c  = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	task automatic advance_capture(input cap_item_t it, output int made);
		sample_beat_t     b;
		logic [31:0]      dur;
		logic [CRC_W-1:0] crc;
		made = 0;
		case (cap_phase)
			ST_WAIT_RISE: begin
				if (it.rise) begin
					cap_phase = ST_WAIT_FALL;
				end
			end
			ST_WAIT_FALL: begin
				if (it.fall) begin
					cap_fill  = 0;
					cap_start = it.now;
					cap_phase = ST_CAPTURE;
				end
			end
			default: begin
				if (it.tick && !it.level && it.ok && cap_fill < FRAME_DEPTH) begin
					cap_store[cap_fill] = it.raw ^ SAMPLE_OFFSET;
					cap_fill++;
				end
				if (it.rise && cap_fill > 0) begin
					cap_frames = cap_frames + 1;
					dur = it.now - cap_start;
					crc = header_crc({16'(cap_fill), dur, cap_start, cap_frames});
					for (int k = 0; k < cap_fill; k++) begin
						b.number = cap_frames;
						b.start  = cap_start;
						b.dur    = dur;
						b.count  = CNT_W'(cap_fill);
						b.crc    = crc;
						b.index  = IDX_W'(k);
						b.value  = cap_store[k];
						b.last   = (k + 1 == cap_fill);
						expected_beats.push_back(b);
					end
					made      = cap_fill;
					cap_fill  = 0;
					cap_start = it.now;
				end
				if (it.fall && cap_fill == 0) begin
					cap_start = it.now;
				end
			end
		endcase
	endtask

	// Idle draw with stretches of no idling.
	function automatic int draw_gap(ref int left, ref bit calm);
		if (left == 0) begin
			left = $urandom_range(10, 30);
			calm = ($urandom_range(0, 2) == 0);
		end
		left--;
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	task automatic send_item(input cap_item_t it, output int made);
		int gap;
		gap = draw_gap(in_left, in_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {it.now, it.raw};
		s_tuser  <= {it.ok, it.level, it.fall, it.rise, it.tick};
		do @(posedge clk); while (!s_tready);
		advance_capture(it, made);
	endtask

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin : out_stall
			int gap;
			gap = draw_gap(out_left, out_calm);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin : beat_check
		sample_beat_t e, g;
		if (arst_n && m_tvalid && m_tready) begin
			g.number = m_tdata[31:0];
			g.start  = m_tdata[63:32];
			g.dur    = m_tdata[95:64];
			g.count  = m_tdata[102:96];
			g.crc    = m_tdata[118:103];
			g.index  = m_tdata[124:119];
			g.value  = m_tdata[140:125];
			g.last   = m_tlast;
			if (expected_beats.size() == 0) begin
				report("unexpected beat", g.index, 0);
			end else begin
				e = expected_beats.pop_front();
				if (g.number !== e.number) report("frame_number", g.number, e.number);
				if (g.start !== e.start) report("start_time", g.start, e.start);
				if (g.dur !== e.dur) report("duration", g.dur, e.dur);
				if (g.count !== e.count) report("sample_count", g.count, e.count);
				if (g.crc !== e.crc) report("header_crc", g.crc, e.crc);
				if (g.index !== e.index) report("sample_index", g.index, e.index);
				if (g.value !== e.value) report("sample_value", g.value, e.value);
				if (g.last !== e.last) report("last", g.last, e.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		cap_item_t   it;
		int          made, total, items, len;
		logic [31:0] clock_ms;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		errors      = 0;
		idle_cycles = 0;
		in_left     = 0;
		out_left    = 0;
		cap_phase   = ST_WAIT_RISE;
		cap_fill    = 0;
		cap_start   = '0;
		cap_frames  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r]) begin
			total = 0;
			for (int n = 0; n < plan[r].reps; n++) begin
				it.tick  = plan[r].tick;
				it.rise  = plan[r].rise;
				it.fall  = plan[r].fall;
				it.level = plan[r].level;
				it.ok    = plan[r].ok;
				it.raw   = (plan[r].reps > 1) ? 16'($urandom) : plan[r].raw;
				it.now   = plan[r].now + n;
				send_item(it, made);
				total += made;
			end
			if (plan[r].want != NO_CHECK && total != plan[r].want) begin
				report("beats caused by table row", total, plan[r].want);
			end
		end

		// Random frames: mostly clean tick runs closed by a rise, with some noise items.
		items    = 0;
		clock_ms = $urandom;
		while (items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				it = cap_item_t'(ITEM_W'({$urandom, $urandom}));
				send_item(it, made);
				items++;
			end else begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70)
				                                  : $urandom_range(1, 8);
				for (int n = 0; n < len; n++) begin
					clock_ms += $urandom_range(0, 40);
					it.tick  = 1'b1;
					it.rise  = 1'b0;
					it.fall  = ($urandom_range(0, 11) == 0);
					it.level = ($urandom_range(0, 9) == 0);
					it.ok    = ($urandom_range(0, 9) != 0);
					it.raw   = 16'($urandom);
					it.now   = clock_ms;
					send_item(it, made);
					items++;
				end
				clock_ms += $urandom_range(0, 40);
				it.tick  = 1'($urandom_range(0, 1));
				it.rise  = 1'b1;
				it.fall  = 1'($urandom_range(0, 1));
				it.level = 1'($urandom_range(0, 1));
				it.ok    = 1'($urandom_range(0, 1));
				it.raw   = 16'($urandom);
				it.now   = clock_ms;
				send_item(it, made);
				items++;
			end
		end
		s_tvalid <= 1'b0;

		while (expected_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
